// ===== rtl/sparse_polynomial_subtract_defines.svh =====
// Assertion macros for the port-level checker of the sparse polynomial subtractor.
// No dependencies; included by the checker file by bare name.
`ifndef SPARSE_POLYNOMIAL_SUBTRACT_DEFINES_SVH
`define SPARSE_POLYNOMIAL_SUBTRACT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define SPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define SPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sps_pkg.sv =====
// Shared constants, command codes and state type of the sparse polynomial subtractor.
// No dependencies; used by the top level and its checker.
package sps_pkg;

    // Terms held for each operand
    localparam int TERMS_PER_OPERAND = 16;
    localparam int CNT_W = $clog2(TERMS_PER_OPERAND + 1);
    localparam int IDX_W = (TERMS_PER_OPERAND > 1) ? $clog2(TERMS_PER_OPERAND) : 1;

    // Field widths
    localparam int COEF_W = 32;
    localparam int EXP_W  = 16;
    localparam int MODE_W = 2;
    localparam int TERM_W = COEF_W + EXP_W;

    // Saturation limits
    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    // Command codes
    localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RUN    = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MERGE = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

endpackage

// ===== rtl/sparse_polynomial_subtract.sv =====
// Sparse polynomial subtractor A - B over two term memories, Q16.16 saturating.
// Depends on sps_pkg.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------------
//  command  | start, busy         | i_mode, i_coef, i_exponent
//  result   | o_strobe            | o_coef_res, o_exponent_res, o_last, o_empty_res,
//           |                     | o_dropped
//
// A load does not raise busy, so another beat may follow in the next cycle.
// A run holds busy through M merge steps (at most terms of A plus terms of B;
// a matched pair takes one step): one step per cycle through the read port of each term
// memory, then a merge check that sees both lists spent, then the flush state for the
// held final term. A term leaves in the cycle after the next kept term is formed, the
// final one in the cycle in which busy drops; at most one beat per cycle.
// Reset (synchronous, active low) clears counts, flags and sequencer; the term
// memories keep their contents. Results cannot be stalled.
module sparse_polynomial_subtract (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [sps_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [sps_pkg::COEF_W-1:0]   i_coef,
    input  logic [sps_pkg::EXP_W-1:0]           i_exponent,
    output logic                                o_strobe,
    output logic signed [sps_pkg::COEF_W-1:0]   o_coef_res,
    output logic [sps_pkg::EXP_W-1:0]           o_exponent_res,
    output logic                                o_last,
    output logic                                o_empty_res,
    output logic                                o_dropped
);

    // Term memories and their registered read data
    logic [sps_pkg::TERM_W-1:0] r_mem_a [sps_pkg::TERMS_PER_OPERAND];
    logic [sps_pkg::TERM_W-1:0] r_mem_b [sps_pkg::TERMS_PER_OPERAND];
    logic [sps_pkg::TERM_W-1:0] r_rd_a;
    logic [sps_pkg::TERM_W-1:0] r_rd_b;

    // Control state
    sps_pkg::t_state             r_state, n_state;
    logic [sps_pkg::CNT_W-1:0]   r_cnt_a, n_cnt_a;
    logic [sps_pkg::CNT_W-1:0]   r_cnt_b, n_cnt_b;
    logic [sps_pkg::CNT_W-1:0]   r_ia, n_ia;
    logic [sps_pkg::CNT_W-1:0]   r_ib, n_ib;
    logic                        r_dropped, n_dropped;
    logic                        r_pend_valid, n_pend_valid;
    logic                        r_strobe, n_strobe;

    // Payload
    logic signed [sps_pkg::COEF_W-1:0] r_pend_coef;
    logic [sps_pkg::EXP_W-1:0]         r_pend_exp;
    logic signed [sps_pkg::COEF_W-1:0] r_out_coef;
    logic [sps_pkg::EXP_W-1:0]         r_out_exp;
    logic                              r_out_last;
    logic                              r_out_empty;
    logic                              r_out_dropped;

    // Datapath
    logic                              accept;
    logic                              we_a, we_b;
    logic signed [sps_pkg::COEF_W-1:0] a_coef, b_coef, sub_lhs, sat_diff, term_coef;
    logic [sps_pkg::EXP_W-1:0]         a_exp, b_exp, term_exp;
    logic signed [sps_pkg::COEF_W:0]   wide_diff;
    logic                              a_ok, b_ok, exp_eq, take_a, produce;
    logic                              emit_pend, emit_final;

    assign accept = start && !busy;
    assign busy   = (r_state != sps_pkg::S_IDLE);

    assign we_a = accept && (i_mode == sps_pkg::MODE_LOAD_A)
                  && (r_cnt_a < sps_pkg::CNT_W'(sps_pkg::TERMS_PER_OPERAND));
    assign we_b = accept && (i_mode == sps_pkg::MODE_LOAD_B)
                  && (r_cnt_b < sps_pkg::CNT_W'(sps_pkg::TERMS_PER_OPERAND));

    // Split the current heads
    assign a_coef = r_rd_a[sps_pkg::TERM_W-1 -: sps_pkg::COEF_W];
    assign a_exp  = r_rd_a[sps_pkg::EXP_W-1:0];
    assign b_coef = r_rd_b[sps_pkg::TERM_W-1 -: sps_pkg::COEF_W];
    assign b_exp  = r_rd_b[sps_pkg::EXP_W-1:0];

    assign a_ok   = (r_ia < r_cnt_a);
    assign b_ok   = (r_ib < r_cnt_b);
    assign exp_eq = a_ok && b_ok && (a_exp == b_exp);
    assign take_a = !exp_eq && (!b_ok || (a_ok && (a_exp > b_exp)));

    // Saturating subtract: A - B on a match, 0 - B for a term of B alone
    assign sub_lhs   = exp_eq ? a_coef : '0;
    assign wide_diff = {sub_lhs[sps_pkg::COEF_W-1], sub_lhs}
                       - {b_coef[sps_pkg::COEF_W-1], b_coef};
    assign sat_diff  = (wide_diff[sps_pkg::COEF_W] != wide_diff[sps_pkg::COEF_W-1])
                       ? (wide_diff[sps_pkg::COEF_W] ? sps_pkg::COEF_MIN : sps_pkg::COEF_MAX)
                       : wide_diff[sps_pkg::COEF_W-1:0];

    assign term_coef = take_a ? a_coef : sat_diff;
    assign term_exp  = take_a ? a_exp  : b_exp;

    // Sequencer and counters
    always_comb begin
        n_state      = r_state;
        n_cnt_a      = r_cnt_a;
        n_cnt_b      = r_cnt_b;
        n_ia         = r_ia;
        n_ib         = r_ib;
        n_dropped    = r_dropped;
        n_pend_valid = r_pend_valid;
        n_strobe     = 1'b0;
        produce      = 1'b0;
        emit_pend    = 1'b0;
        emit_final   = 1'b0;
        unique case (r_state)
            sps_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_mode)
                        sps_pkg::MODE_LOAD_A: begin
                            if (we_a) n_cnt_a = r_cnt_a + 1'b1;
                            else      n_dropped = 1'b1;
                        end
                        sps_pkg::MODE_LOAD_B: begin
                            if (we_b) n_cnt_b = r_cnt_b + 1'b1;
                            else      n_dropped = 1'b1;
                        end
                        sps_pkg::MODE_RUN: begin
                            n_state = sps_pkg::S_MERGE;
                        end
                        default: begin
                            n_state = sps_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            sps_pkg::S_MERGE: begin
                if (!a_ok && !b_ok) begin
                    n_state = sps_pkg::S_FLUSH;
                end else begin
                    // Advance the heads that were consumed
                    if (exp_eq || take_a)  n_ia = r_ia + 1'b1;
                    if (exp_eq || !take_a) n_ib = r_ib + 1'b1;
                    // Drop a match that cancels
                    produce = !(exp_eq && (sat_diff == '0));
                    if (produce) begin
                        emit_pend    = r_pend_valid;
                        n_strobe     = r_pend_valid;
                        n_pend_valid = 1'b1;
                    end
                end
            end
            sps_pkg::S_FLUSH: begin
                emit_final   = 1'b1;
                n_strobe     = 1'b1;
                n_pend_valid = 1'b0;
                n_cnt_a      = '0;
                n_cnt_b      = '0;
                n_ia         = '0;
                n_ib         = '0;
                n_dropped    = 1'b0;
                n_state      = sps_pkg::S_IDLE;
            end
            default: begin
                n_state = sps_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sps_pkg::S_IDLE;
            r_cnt_a      <= '0;
            r_cnt_b      <= '0;
            r_ia         <= '0;
            r_ib         <= '0;
            r_dropped    <= 1'b0;
            r_pend_valid <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt_a      <= n_cnt_a;
            r_cnt_b      <= n_cnt_b;
            r_ia         <= n_ia;
            r_ib         <= n_ib;
            r_dropped    <= n_dropped;
            r_pend_valid <= n_pend_valid;
            r_strobe     <= n_strobe;
        end
    end

    // Write loaded terms; read the next heads so data lines up with the indices
    always_ff @(posedge i_clk) begin
        if (we_a) r_mem_a[r_cnt_a[sps_pkg::IDX_W-1:0]] <= {i_coef, i_exponent};
        r_rd_a <= r_mem_a[n_ia[sps_pkg::IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (we_b) r_mem_b[r_cnt_b[sps_pkg::IDX_W-1:0]] <= {i_coef, i_exponent};
        r_rd_b <= r_mem_b[n_ib[sps_pkg::IDX_W-1:0]];
    end

    // Hold the newest term back until it is known whether it is the last one
    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_pend_coef <= term_coef;
            r_pend_exp  <= term_exp;
        end
        if (emit_pend) begin
            r_out_coef    <= r_pend_coef;
            r_out_exp     <= r_pend_exp;
            r_out_last    <= 1'b0;
            r_out_empty   <= 1'b0;
            r_out_dropped <= r_dropped;
        end else if (emit_final) begin
            r_out_coef    <= r_pend_valid ? r_pend_coef : '0;
            r_out_exp     <= r_pend_valid ? r_pend_exp  : '0;
            r_out_last    <= 1'b1;
            r_out_empty   <= !r_pend_valid;
            r_out_dropped <= r_dropped;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_coef_res     = r_out_coef;
    assign o_exponent_res = r_out_exp;
    assign o_last         = r_out_last;
    assign o_empty_res    = r_out_empty;
    assign o_dropped      = r_out_dropped;

endmodule

// ===== rtl/sps_checker.sv =====
// Port-level checker for the sparse polynomial subtractor, bound to the top level.
// Depends on sps_pkg and sparse_polynomial_subtract_defines.svh.
`include "sparse_polynomial_subtract_defines.svh"

module sps_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic [sps_pkg::MODE_W-1:0]          i_mode,
    input logic signed [sps_pkg::COEF_W-1:0]   i_coef,
    input logic [sps_pkg::EXP_W-1:0]           i_exponent,
    input logic                                o_strobe,
    input logic signed [sps_pkg::COEF_W-1:0]   o_coef_res,
    input logic [sps_pkg::EXP_W-1:0]           o_exponent_res,
    input logic                                o_last,
    input logic                                o_empty_res,
    input logic                                o_dropped
);

    // An empty difference is a single, zeroed, final beat
    `SPS_ASSERT_NOW(a_empty_is_last, i_clk, i_rst_n, o_strobe && o_empty_res, o_last && (o_coef_res == '0) && (o_exponent_res == '0), "empty result not a zeroed last beat")

    // A run command starts the merge at once
    `SPS_ASSERT_NEXT(a_run_goes_busy, i_clk, i_rst_n, start && !busy && (i_mode == sps_pkg::MODE_RUN), busy, "run accepted without going busy")

    // More beats follow a non-final one, so the run is still going
    `SPS_ASSERT_NOW(a_mid_run_busy, i_clk, i_rst_n, o_strobe && !o_last, busy, "non-final beat outside a run")

    // The final beat leaves the block free for commands
    `SPS_ASSERT_NOW(a_last_idle, i_clk, i_rst_n, o_strobe && o_last, !busy, "still busy on final beat")

    // Loads from idle, with no run just ended, never produce results in the next cycle
    `SPS_ASSERT_NEXT(a_load_silent, i_clk, i_rst_n, !busy && !$past(busy) && !o_strobe && start && (i_mode != sps_pkg::MODE_RUN), !o_strobe, "result beat after a load")

endmodule

bind sparse_polynomial_subtract sps_checker u_sps_checker (.*);

// ===== bench/sps_diff_checker.sv =====
`timescale 1ns / 100ps
// Checker of the sparse polynomial subtractor: watches command and result beats,
// predicts each run's difference terms and compares them. Depends on sps_pkg.
module sps_diff_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [sps_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [sps_pkg::COEF_W-1:0]   i_coef,
    input  logic [sps_pkg::EXP_W-1:0]           i_exponent,
    input  logic                                o_strobe,
    input  logic signed [sps_pkg::COEF_W-1:0]   o_coef_res,
    input  logic [sps_pkg::EXP_W-1:0]           o_exponent_res,
    input  logic                                o_last,
    input  logic                                o_empty_res,
    input  logic                                o_dropped,
    output int                                  pending,
    output int                                  fail_count
);

    typedef struct packed {
        logic signed [sps_pkg::COEF_W-1:0] coef;
        logic [sps_pkg::EXP_W-1:0]         expo;
        logic                              last;
        logic                              empty;
        logic                              dropped;
    } t_diff_term;

    // Own copy of the two term stores
    logic signed [sps_pkg::COEF_W-1:0] a_coef [sps_pkg::TERMS_PER_OPERAND];
    logic [sps_pkg::EXP_W-1:0]         a_exp  [sps_pkg::TERMS_PER_OPERAND];
    logic signed [sps_pkg::COEF_W-1:0] b_coef [sps_pkg::TERMS_PER_OPERAND];
    logic [sps_pkg::EXP_W-1:0]         b_exp  [sps_pkg::TERMS_PER_OPERAND];
    int                                a_len;
    int                                b_len;
    logic                              lost_term;

    t_diff_term diff_terms_due[$];

    // Saturating x - y over the coefficient width
    function automatic logic signed [sps_pkg::COEF_W-1:0] sat_diff(
        input logic signed [sps_pkg::COEF_W-1:0] x,
        input logic signed [sps_pkg::COEF_W-1:0] y
    );
        logic signed [sps_pkg::COEF_W:0] d;
        d = $signed({x[sps_pkg::COEF_W-1], x}) - $signed({y[sps_pkg::COEF_W-1], y});
        if (d[sps_pkg::COEF_W] != d[sps_pkg::COEF_W-1])
            return d[sps_pkg::COEF_W] ? sps_pkg::COEF_MIN : sps_pkg::COEF_MAX;
        return d[sps_pkg::COEF_W-1:0];
    endfunction

    // Merge both stores by exponent and queue the terms of A - B
    task automatic merge_difference();
        int                                ia;
        int                                ib;
        int                                n;
        logic signed [sps_pkg::COEF_W-1:0] rc;
        logic [sps_pkg::EXP_W-1:0]         re;
        logic                              emit;
        t_diff_term                        t;
        ia = 0;
        ib = 0;
        n  = 0;
        while (ia < a_len || ib < b_len) begin
            emit = 1'b1;
            if (ia < a_len && ib < b_len && a_exp[ia] == b_exp[ib]) begin
                rc   = sat_diff(a_coef[ia], b_coef[ib]);
                re   = a_exp[ia];
                ia++;
                ib++;
                emit = (rc != 0);
            end else if (ib >= b_len || (ia < a_len && a_exp[ia] > b_exp[ib])) begin
                rc = a_coef[ia];
                re = a_exp[ia];
                ia++;
            end else begin
                rc = sat_diff('0, b_coef[ib]);
                re = b_exp[ib];
                ib++;
            end
            if (emit) begin
                t = '{coef: rc, expo: re, last: 1'b0, empty: 1'b0, dropped: lost_term};
                diff_terms_due.push_back(t);
                n++;
            end
        end
        // Mark the final term, or stand in an empty marker
        if (n == 0) begin
            t = '{coef: '0, expo: '0, last: 1'b1, empty: 1'b1, dropped: lost_term};
            diff_terms_due.push_back(t);
        end else begin
            t = diff_terms_due.pop_back();
            t.last = 1'b1;
            diff_terms_due.push_back(t);
        end
        a_len     = 0;
        b_len     = 0;
        lost_term = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_diff_term want;
        if (!i_rst_n) begin
            a_len      = 0;
            b_len      = 0;
            lost_term  = 1'b0;
            fail_count = 0;
            diff_terms_due.delete();
        end else begin
            // Compare each result beat with the oldest expected term
            if (o_strobe) begin
                if (diff_terms_due.size() == 0) begin
                    $error("unexpected result: coef_res %0d exponent_res %0d",
                           o_coef_res, o_exponent_res);
                    fail_count++;
                end else begin
                    want = diff_terms_due.pop_front();
                    if (o_coef_res !== want.coef) begin
                        $error("coef_res: expected %0d, got %0d", want.coef, o_coef_res);
                        fail_count++;
                    end
                    if (o_exponent_res !== want.expo) begin
                        $error("exponent_res: expected %0d, got %0d",
                               want.expo, o_exponent_res);
                        fail_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, o_last);
                        fail_count++;
                    end
                    if (o_empty_res !== want.empty) begin
                        $error("empty_res: expected %0d, got %0d", want.empty, o_empty_res);
                        fail_count++;
                    end
                    if (o_dropped !== want.dropped) begin
                        $error("dropped: expected %0d, got %0d", want.dropped, o_dropped);
                        fail_count++;
                    end
                end
            end
            // Predict on every accepted command beat
            if (start && !busy) begin
                case (i_mode)
                    sps_pkg::MODE_LOAD_A: begin
                        if (a_len < sps_pkg::TERMS_PER_OPERAND) begin
                            a_coef[a_len] = i_coef;
                            a_exp[a_len]  = i_exponent;
                            a_len++;
                        end else begin
                            lost_term = 1'b1;
                        end
                    end
                    sps_pkg::MODE_LOAD_B: begin
                        if (b_len < sps_pkg::TERMS_PER_OPERAND) begin
                            b_coef[b_len] = i_coef;
                            b_exp[b_len]  = i_exponent;
                            b_len++;
                        end else begin
                            lost_term = 1'b1;
                        end
                    end
                    sps_pkg::MODE_RUN: begin
                        merge_difference();
                    end
                    default: begin
                    end
                endcase
            end
        end
        pending <= diff_terms_due.size();
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Top of the sparse polynomial subtractor bench: clock, reset, directed and random
// command beats. Depends on sps_pkg, sparse_polynomial_subtract and sps_diff_checker.
module tb;

    localparam logic [sps_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_BEATS = 260;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic [sps_pkg::MODE_W-1:0]        i_mode = sps_pkg::MODE_LOAD_A;
    logic signed [sps_pkg::COEF_W-1:0] i_coef = '0;
    logic [sps_pkg::EXP_W-1:0]         i_exponent = '0;
    logic                              o_strobe;
    logic signed [sps_pkg::COEF_W-1:0] o_coef_res;
    logic [sps_pkg::EXP_W-1:0]         o_exponent_res;
    logic                              o_last;
    logic                              o_empty_res;
    logic                              o_dropped;
    int                                pending;
    int                                fail_count;

    int                                beats_sent = 0;
    bit                                calm = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    sparse_polynomial_subtract DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_coef         (i_coef),
        .i_exponent     (i_exponent),
        .o_strobe       (o_strobe),
        .o_coef_res     (o_coef_res),
        .o_exponent_res (o_exponent_res),
        .o_last         (o_last),
        .o_empty_res    (o_empty_res),
        .o_dropped      (o_dropped)
    );

    sps_diff_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_coef         (i_coef),
        .i_exponent     (i_exponent),
        .o_strobe       (o_strobe),
        .o_coef_res     (o_coef_res),
        .o_exponent_res (o_exponent_res),
        .o_last         (o_last),
        .o_empty_res    (o_empty_res),
        .o_dropped      (o_dropped),
        .pending        (pending),
        .fail_count     (fail_count)
    );

    // Unless calm, hold off a random gap, then present one command beat until it is taken
    task automatic send_beat(
        input logic [sps_pkg::MODE_W-1:0]        mode,
        input logic signed [sps_pkg::COEF_W-1:0] coef,
        input logic [sps_pkg::EXP_W-1:0]         expo
    );
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_mode     <= mode;
        i_coef     <= coef;
        i_exponent <= expo;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (mode != MODE_UNUSED)
            beats_sent++;
    endtask

    // Coefficient with extra weight on the limits and on tiny values
    function automatic logic signed [sps_pkg::COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 7))
            0:       return sps_pkg::COEF_MAX;
            1:       return sps_pkg::COEF_MIN;
            2:       return int'($urandom_range(0, 4)) - 2;
            default: return $urandom;
        endcase
    endfunction

    // Build two mostly descending term lists with shared exponents, load them interleaved, run
    task automatic random_run();
        logic [sps_pkg::EXP_W-1:0]         ea[$];
        logic [sps_pkg::EXP_W-1:0]         eb[$];
        logic signed [sps_pkg::COEF_W-1:0] ca[$];
        logic signed [sps_pkg::COEF_W-1:0] cb[$];
        logic signed [sps_pkg::COEF_W-1:0] c;
        int                                m;
        int                                e;
        int                                pick;
        int                                ia;
        int                                ib;
        int                                k;
        calm = ($urandom_range(0, 3) == 0);
        m = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 22) : $urandom_range(0, 8);
        e = ($urandom_range(0, 5) == 0) ? 65535 : $urandom_range(0, 65535);
        for (k = 0; k < m && e >= 0; k++) begin
            pick = $urandom_range(0, 2);
            c    = pick_coef();
            if (pick != 1) begin
                ea.push_back(sps_pkg::EXP_W'(e));
                ca.push_back(c);
            end
            if (pick != 0) begin
                case ($urandom_range(0, 3))
                    0:       cb.push_back(c);
                    1:       cb.push_back(c + 1);
                    default: cb.push_back(pick_coef());
                endcase
                eb.push_back(sps_pkg::EXP_W'(e));
            end
            e -= ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 8192);
        end
        // Overfill one store now and then
        if ($urandom_range(0, 7) == 0) begin
            k = sps_pkg::TERMS_PER_OPERAND + $urandom_range(1, 3);
            if ($urandom_range(0, 1) == 0) begin
                while (ea.size() < k) begin
                    ea.push_back(sps_pkg::EXP_W'($urandom_range(0, 65535)));
                    ca.push_back(pick_coef());
                end
            end else begin
                while (eb.size() < k) begin
                    eb.push_back(sps_pkg::EXP_W'($urandom_range(0, 65535)));
                    cb.push_back(pick_coef());
                end
            end
        end
        // Break the descending order now and then
        if ($urandom_range(0, 11) == 0 && ea.size() > 0)
            ea[$urandom_range(0, ea.size() - 1)] = sps_pkg::EXP_W'($urandom_range(0, 65535));
        if ($urandom_range(0, 11) == 0 && eb.size() > 0)
            eb[$urandom_range(0, eb.size() - 1)] = sps_pkg::EXP_W'($urandom_range(0, 65535));
        ia = 0;
        ib = 0;
        while (ia < ea.size() || ib < eb.size()) begin
            if ($urandom_range(0, 19) == 0)
                send_beat(MODE_UNUSED, $urandom, sps_pkg::EXP_W'($urandom));
            if (ib >= eb.size() || (ia < ea.size() && $urandom_range(0, 1) == 0)) begin
                send_beat(sps_pkg::MODE_LOAD_A, ca[ia], ea[ia]);
                ia++;
            end else begin
                send_beat(sps_pkg::MODE_LOAD_B, cb[ib], eb[ib]);
                ib++;
            end
        end
        send_beat(sps_pkg::MODE_RUN, $urandom, sps_pkg::EXP_W'($urandom));
    endtask

    initial begin
        int goal;
        // Hold reset, then release it
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Run with both stores empty
        send_beat(sps_pkg::MODE_RUN, '0, '0);

        // Saturating difference, only-A, only-B negation at the limit, cancellation
        send_beat(sps_pkg::MODE_LOAD_A, sps_pkg::COEF_MAX, 16'hFFFF);
        send_beat(sps_pkg::MODE_LOAD_B, sps_pkg::COEF_MIN, 16'hFFFF);
        send_beat(sps_pkg::MODE_LOAD_A, -3, 16'd7);
        send_beat(sps_pkg::MODE_LOAD_A, 1, 16'd5);
        send_beat(sps_pkg::MODE_LOAD_B, 1, 16'd5);
        send_beat(sps_pkg::MODE_LOAD_B, sps_pkg::COEF_MIN, 16'd3);
        send_beat(sps_pkg::MODE_LOAD_A, sps_pkg::COEF_MIN, 16'd0);
        send_beat(sps_pkg::MODE_LOAD_B, 1, 16'd0);
        send_beat(MODE_UNUSED, $urandom, sps_pkg::EXP_W'($urandom));
        send_beat(sps_pkg::MODE_RUN, '0, '0);

        // Every term cancels
        send_beat(sps_pkg::MODE_LOAD_A, 5, 16'd10);
        send_beat(sps_pkg::MODE_LOAD_B, 5, 16'd10);
        send_beat(sps_pkg::MODE_RUN, '0, '0);

        // Exponents out of order
        send_beat(sps_pkg::MODE_LOAD_A, 1, 16'd3);
        send_beat(sps_pkg::MODE_LOAD_A, 2, 16'd9);
        send_beat(sps_pkg::MODE_LOAD_B, 4, 16'd5);
        send_beat(sps_pkg::MODE_RUN, '0, '0);

        // Zero coefficient found only in A passes through
        send_beat(sps_pkg::MODE_LOAD_A, 0, 16'd1);
        send_beat(sps_pkg::MODE_RUN, '0, '0);

        // Random runs
        goal = beats_sent + RANDOM_BEATS;
        while (beats_sent < goal)
            random_run();
        start <= 1'b0;

        // Drain the expected terms, then wait quietly before the verdict
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Stop a hung run
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sps_pkg.sv
rtl/sparse_polynomial_subtract.sv
rtl/sps_checker.sv
bench/sps_diff_checker.sv
bench/tb.sv
